FILE: hw/rtl/lhcf_pkg.sv
// Package: shared constants, register indexes and control structs for the lane histogram core.
`timescale 1ns / 1ps

package lhcf_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_ROWS  = 128;

    localparam int COL_W    = 10;
    localparam int ROW_W    = 7;
    localparam int CNT_W    = 8;
    localparam int FW_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int POS_W    = 10;
    localparam int RPOS_W   = 11;
    localparam int CTR_W    = 11;
    localparam int OFS_W    = 12;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_END     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;

    // register reset values
    localparam logic [6:0]  RST_BAND_TOP     = 7'd10;
    localparam logic [7:0]  RST_BAND_ROWS    = 8'd100;
    localparam logic [9:0]  RST_LEFT_END     = 10'd150;
    localparam logic [9:0]  RST_RIGHT_START  = 10'd250;
    localparam logic [9:0]  RST_FRAME_CENTER = 10'd244;
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd800;

    typedef struct packed {
        logic clr;        // reset sweep: zero entry at counter, advance
        logic take_pix;   // accept input beat, read its column count
        logic upd;        // write back incremented count
        logic scan_init;  // counter to zero, clear peak trackers
        logic scan;       // read and zero entry at counter, advance
        logic calc;       // resolve positions and half difference
        logic load;       // load output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic width_zero;
        logic eof;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/lane_histogram_center_finder_core.sv
// Top level: lane histogram center finder, controller plus datapath.
`timescale 1ns / 1ps

// Counts lane pixels per column inside a row band and, on the last pixel of a frame,
// reports the peak column of the left and right search ranges, their midpoint and its
// signed offset from the reference column. Each pixel beat is a read and a write-back
// of its column count in the single-port count memory. The beat that ends a frame adds
// a scan of the column counts, one column per cycle over the width in use (further, up
// to the highest column counted, if the width was lowered mid-frame), then a drain
// state, a calc state that forms the result and an output state; with nothing to scan
// only the calc and output states are added. The output state waits while an earlier
// result is still held unaccepted; otherwise the result register holds a finished
// result while the next pixels are taken. After reset the count memory is cleared over
// all MAX_WIDTH entries, during which input is stalled; configuration writes are taken
// at any time and must only be made while the block is idle.
module lane_histogram_center_finder_core
    import lhcf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = DEF_MAX_ROWS
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_lane_pixel,
    input  logic [COL_W-1:0]        i_column,
    input  logic [ROW_W-1:0]        i_row,
    input  logic                    i_end_of_frame,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_left_pos,
    output logic [RPOS_W-1:0]       o_right_pos,
    output logic [CTR_W-1:0]        o_lane_center,
    output logic signed [OFS_W-1:0] o_steer_offset
);

    t_cmd    cmd;
    t_status status;

    lhcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lhcf_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_lane_pixel   (i_lane_pixel),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_end_of_frame (i_end_of_frame),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_left_pos     (o_left_pos),
        .o_right_pos    (o_right_pos),
        .o_lane_center  (o_lane_center),
        .o_steer_offset (o_steer_offset)
    );

endmodule

FILE: hw/rtl/lhcf_ctrl.sv
// Controller: sequences reset sweep, pixel read-modify-write, end-of-frame scan and result load.
`timescale 1ns / 1ps

module lhcf_ctrl
    import lhcf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_CALC  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_pix = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_status.eof) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = i_status.width_zero ? S_CALC : S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/lhcf_dp.sv
// Datapath: config registers, column count memory, peak trackers and result registers.
`timescale 1ns / 1ps

module lhcf_dp
    import lhcf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = DEF_MAX_ROWS
)
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                        i_lane_pixel,
    input  logic [COL_W-1:0]            i_column,
    input  logic [ROW_W-1:0]            i_row,
    input  logic                        i_end_of_frame,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [POS_W-1:0]            o_left_pos,
    output logic [RPOS_W-1:0]           o_right_pos,
    output logic [CTR_W-1:0]            o_lane_center,
    output logic signed [OFS_W-1:0]     o_steer_offset
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int MWW = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (MWW > FW_W) ? MWW : FW_W;
    localparam int DW  = WW + 2;

    // configuration
    logic [6:0]  r_band_top;
    logic [7:0]  r_band_rows;
    logic [9:0]  r_left_end;
    logic [9:0]  r_right_start;
    logic [9:0]  r_frame_center;
    logic [10:0] r_frame_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_top     <= RST_BAND_TOP;
            r_band_rows    <= RST_BAND_ROWS;
            r_left_end     <= RST_LEFT_END;
            r_right_start  <= RST_RIGHT_START;
            r_frame_center <= RST_FRAME_CENTER;
            r_frame_width  <= RST_FRAME_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BAND_TOP:     r_band_top     <= i_cfg_data[6:0];
                REG_BAND_ROWS:    r_band_rows    <= i_cfg_data[7:0];
                REG_LEFT_END:     r_left_end     <= i_cfg_data[9:0];
                REG_RIGHT_START:  r_right_start  <= i_cfg_data[9:0];
                REG_FRAME_CENTER: r_frame_center <= i_cfg_data[9:0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] wu;
    logic [WW-1:0] lend;
    logic [WW-1:0] rstart;

    assign wu     = (WW'(r_frame_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                          : WW'(r_frame_width);
    assign lend   = (WW'(r_left_end) < wu) ? WW'(r_left_end) : wu;
    assign rstart = WW'(r_right_start);

    // pixel capture
    logic          hit;
    logic          r_hit;
    logic [AW-1:0] r_col;
    logic          r_eof;

    assign hit = i_lane_pixel
              && (WW'(i_column) < wu)
              && (int'(i_row) < MAX_ROWS)
              && (i_row >= r_band_top)
              && ((8'(i_row) - 8'(r_band_top)) < r_band_rows);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pix) begin
            r_hit <= hit;
            r_col <= AW'(i_column);
            r_eof <= i_end_of_frame;
        end
    end

    // highest counted column + 1 in this frame; the scan also clears up to it
    logic [WW-1:0] r_top;
    logic [WW-1:0] scan_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.calc) begin
            r_top <= '0;
        end else if (i_cmd.upd && r_hit && (WW'(r_col) >= r_top)) begin
            r_top <= WW'(r_col) + 1'b1;
        end
    end

    assign scan_end = (r_top > wu) ? r_top : wu;

    // sweep counter
    logic [AW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_init) begin
            r_cnt <= '0;
        end else if (i_cmd.clr || i_cmd.scan) begin
            r_cnt <= (r_cnt == AW'(MAX_WIDTH - 1)) ? '0 : r_cnt + 1'b1;
        end
    end

    // column count memory
    logic [CNT_W-1:0] r_mem [MAX_WIDTH];
    logic [CNT_W-1:0] r_rd_data;
    logic [AW-1:0]    rd_addr;

    assign rd_addr = i_cmd.take_pix ? AW'(i_column) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.scan) begin
            r_mem[r_cnt] <= '0;
        end else if (i_cmd.upd && r_hit) begin
            r_mem[r_col] <= (r_rd_data == COUNT_MAX) ? COUNT_MAX : r_rd_data + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pix || i_cmd.scan) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // scan: r_sa is registered together with the read data, so it names the column of r_rd_data
    logic             r_sv;
    logic [AW-1:0]    r_sa;
    logic             r_lv;
    logic             r_rv;
    logic [WW-1:0]    r_lpos;
    logic [WW-1:0]    r_rpos;
    logic [CNT_W-1:0] r_lbest;
    logic [CNT_W-1:0] r_rbest;
    logic             in_left;
    logic             in_right;

    assign in_left  = WW'(r_sa) < lend;
    assign in_right = (WW'(r_sa) >= rstart) && (WW'(r_sa) < wu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= i_cmd.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa <= r_cnt;
        if (i_cmd.scan_init) begin
            r_lv <= 1'b0;
            r_rv <= 1'b0;
        end else if (r_sv) begin
            if (in_left && (!r_lv || r_rd_data > r_lbest)) begin
                r_lv    <= 1'b1;
                r_lbest <= r_rd_data;
                r_lpos  <= WW'(r_sa);
            end
            if (in_right && (!r_rv || r_rd_data > r_rbest)) begin
                r_rv    <= 1'b1;
                r_rbest <= r_rd_data;
                r_rpos  <= WW'(r_sa);
            end
        end
    end

    // result
    logic [WW-1:0]        left_sel;
    logic [WW-1:0]        right_sel;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] diff_adj;
    logic [WW-1:0]        r_left;
    logic [WW-1:0]        r_right;
    logic signed [DW-1:0] r_half;
    logic signed [DW-1:0] center;
    logic signed [DW-1:0] offset;

    assign left_sel  = r_lv ? r_lpos : '0;
    assign right_sel = (rstart < wu) ? r_rpos : wu;
    assign diff      = signed'(DW'(right_sel)) - signed'(DW'(left_sel));
    // truncate toward zero on halving
    assign diff_adj  = diff + signed'({{(DW-1){1'b0}}, diff[DW-1]});

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_left  <= left_sel;
            r_right <= right_sel;
            r_half  <= diff_adj >>> 1;
        end
    end

    assign center = r_half + signed'(DW'(r_left));
    assign offset = center - signed'(DW'(r_frame_center));

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_left_pos     <= POS_W'(r_left);
            o_right_pos    <= RPOS_W'(r_right);
            o_lane_center  <= CTR_W'(center);
            o_steer_offset <= OFS_W'(offset);
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_status.clr_last   = (r_cnt == AW'(MAX_WIDTH - 1));
    assign o_status.scan_last  = (WW'(r_cnt) == scan_end - 1'b1);
    assign o_status.width_zero = (scan_end == '0);
    assign o_status.eof        = r_eof;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

FILE: verif/lane_histogram_center_finder_core_tb.sv
// Testbench for lane_histogram_center_finder_core: pixel frames checked against a column-count predictor.
`timescale 1ns / 1ps

module lane_histogram_center_finder_core_tb
    import lhcf_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TAIL_CYCLES    = 1100;
    localparam int BEAT_TARGET    = 1300;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum {STALL_NONE, STALL_SCATTER, STALL_LONG} t_stall_mode;

    typedef struct {
        logic [POS_W-1:0]        left_pos;
        logic [RPOS_W-1:0]       right_pos;
        logic [CTR_W-1:0]        lane_center;
        logic signed [OFS_W-1:0] steer_offset;
    } t_lane_fix;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]    i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_lane_pixel = 1'b0;
    logic [COL_W-1:0]        i_column = '0;
    logic [ROW_W-1:0]        i_row = '0;
    logic                    i_end_of_frame = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [POS_W-1:0]        o_left_pos;
    logic [RPOS_W-1:0]       o_right_pos;
    logic [CTR_W-1:0]        o_lane_center;
    logic signed [OFS_W-1:0] o_steer_offset;

    // predictor state
    logic [CNT_W-1:0] col_hist [DEF_MAX_WIDTH];
    logic [ROW_W-1:0] m_band_top      = RST_BAND_TOP;
    logic [CNT_W-1:0] m_band_rows     = RST_BAND_ROWS;
    logic [COL_W-1:0] m_left_end      = RST_LEFT_END;
    logic [COL_W-1:0] m_right_start   = RST_RIGHT_START;
    logic [COL_W-1:0] m_frame_center  = RST_FRAME_CENTER;
    logic [FW_W-1:0]  m_frame_width   = RST_FRAME_WIDTH;

    t_lane_fix   pending_fixes [$];
    int          mismatch_count = 0;
    int          beats_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_timer = 0;
    int          stall_run = 0;

    lane_histogram_center_finder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_lane_pixel   (i_lane_pixel),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_end_of_frame (i_end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_pos     (o_left_pos),
        .o_right_pos    (o_right_pos),
        .o_lane_center  (o_lane_center),
        .o_steer_offset (o_steer_offset)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        foreach (col_hist[i]) col_hist[i] = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic int used_width();
        return (m_frame_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(m_frame_width);
    endfunction

    // first column with the largest count in [lo, hi); hi when empty
    function automatic int peak_column(input int lo, input int hi);
        int best;
        best = hi;
        for (int c = lo; c < hi; c++) begin
            if (best == hi || col_hist[c] > col_hist[best]) best = c;
        end
        return best;
    endfunction

    task automatic tally_pixel(input logic pix, input logic [COL_W-1:0] col,
                               input logic [ROW_W-1:0] row, input logic eof);
        int        w;
        int        lend;
        int        left;
        int        right;
        int        center;
        int        offset;
        t_lane_fix fix;
        w = used_width();
        if (pix && int'(col) < w && row >= m_band_top &&
            int'(row) - int'(m_band_top) < int'(m_band_rows) && col_hist[col] != COUNT_MAX) begin
            col_hist[col]++;
        end
        if (!eof) return;
        lend = (int'(m_left_end) < w) ? int'(m_left_end) : w;
        left = peak_column(0, lend);
        if (left == lend) left = 0;
        right = (int'(m_right_start) < w) ? peak_column(int'(m_right_start), w) : w;
        center = (right - left) / 2 + left;
        offset = center - int'(m_frame_center);
        fix.left_pos     = POS_W'(left);
        fix.right_pos    = RPOS_W'(right);
        fix.lane_center  = CTR_W'(center);
        fix.steer_offset = OFS_W'(offset);
        pending_fixes = {pending_fixes, fix};
        foreach (col_hist[i]) col_hist[i] = '0;
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_BAND_TOP:     m_band_top     = data[ROW_W-1:0];
            REG_BAND_ROWS:    m_band_rows    = data[CNT_W-1:0];
            REG_LEFT_END:     m_left_end     = data[COL_W-1:0];
            REG_RIGHT_START:  m_right_start  = data[COL_W-1:0];
            REG_FRAME_CENTER: m_frame_center = data[COL_W-1:0];
            REG_FRAME_WIDTH:  m_frame_width  = data[FW_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(input int bt, input int br, input int le, input int rs,
                           input int fc, input int fw);
        set_register(REG_BAND_TOP, CFG_DAT_W'(bt));
        set_register(REG_BAND_ROWS, CFG_DAT_W'(br));
        set_register(REG_LEFT_END, CFG_DAT_W'(le));
        set_register(REG_RIGHT_START, CFG_DAT_W'(rs));
        set_register(REG_FRAME_CENTER, CFG_DAT_W'(fc));
        set_register(REG_FRAME_WIDTH, CFG_DAT_W'(fw));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_fixes.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic pix, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic eof);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_lane_pixel   <= pix;
        i_column       <= col;
        i_row          <= row;
        i_end_of_frame <= eof;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        tally_pixel(pix, col, row, eof);
    endtask

    task automatic test_directed();
        send_beat(1'b1, 100, 10, 1'b0);
        send_beat(1'b1, 100, 109, 1'b0);
        send_beat(1'b1, 100, 110, 1'b0);
        send_beat(1'b1, 5, 9, 1'b0);
        send_beat(1'b1, 300, 50, 1'b0);
        send_beat(1'b1, 300, 60, 1'b0);
        send_beat(1'b1, 299, 50, 1'b0);
        send_beat(1'b1, 1023, 127, 1'b0);
        send_beat(1'b0, 0, 0, 1'b0);
        send_beat(1'b1, 299, 20, 1'b1);
        send_beat(1'b0, 1023, 127, 1'b1);
        send_beat(1'b1, 149, 50, 1'b0);
        send_beat(1'b1, 149, 51, 1'b0);
        send_beat(1'b1, 799, 50, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_register(REG_FRAME_CENTER, 11'd1023);
        set_register(REG_FRAME_WIDTH, 11'd0);
        send_beat(1'b1, 0, 50, 1'b1);
        wait_idle();
        set_all(127, 1, 1023, 1023, 0, 2047);
        send_beat(1'b1, 1022, 127, 1'b0);
        send_beat(1'b1, 1023, 127, 1'b0);
        send_beat(1'b1, 1023, 127, 1'b1);
        wait_idle();
        set_register(REG_BAND_ROWS, 11'd0);
        send_beat(1'b1, 5, 127, 1'b1);
        wait_idle();
        set_all(0, 255, 1, 0, 512, 1);
        send_beat(1'b1, 0, 0, 1'b0);
        send_beat(1'b1, 1, 0, 1'b1);
        wait_idle();
        set_register(REG_UNMAPPED_LO, 11'h7ff);
        set_register(REG_UNMAPPED_HI, 11'h555);
        send_beat(1'b1, 0, 127, 1'b1);
    endtask

    // column 40 gets more hits than column 20, but both stop at the count ceiling
    task automatic test_saturation();
        int left_lo;
        int left_hi;
        int right_hits;
        int pick;
        logic [COL_W-1:0] col;
        left_lo = 255;
        left_hi = 262;
        right_hits = 3;
        wait_idle();
        set_all(0, 128, 150, 250, 244, 800);
        while (left_lo + left_hi + right_hits > 0) begin
            pick = $urandom_range(0, left_lo + left_hi + right_hits - 1);
            if (pick < left_lo) begin
                col = 20;
                left_lo--;
            end else if (pick < left_lo + left_hi) begin
                col = 40;
                left_hi--;
            end else begin
                col = 300;
                right_hits--;
            end
            send_beat(1'b1, col, ROW_W'($urandom_range(0, 127)),
                      (left_lo + left_hi + right_hits) == 0);
        end
    endtask

    function automatic logic [CFG_DAT_W-1:0] with_junk(input int value, input int width);
        logic [CFG_DAT_W-1:0] data;
        data = CFG_DAT_W'(value);
        if ($urandom_range(0, 3) == 0) data |= CFG_DAT_W'($urandom()) << width;
        return data;
    endfunction

    task automatic randomize_registers();
        int fw;
        int wl;
        case ($urandom_range(0, 9))
            0: fw = 0;
            1: fw = 1024;
            2: fw = $urandom_range(1025, 2047);
            3: fw = 1;
            default: fw = $urandom_range(2, 1024);
        endcase
        wl = (fw > 1023) ? 1023 : fw;
        set_register(REG_BAND_TOP, with_junk($urandom_range(0, 127), ROW_W));
        set_register(REG_BAND_ROWS,
                     with_junk(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255), CNT_W));
        set_register(REG_LEFT_END, with_junk(($urandom_range(0, 4) == 0) ?
                     $urandom_range(0, 1023) : $urandom_range(0, wl), COL_W));
        set_register(REG_RIGHT_START, with_junk(($urandom_range(0, 4) == 0) ?
                     $urandom_range(0, 1023) : $urandom_range(0, wl), COL_W));
        set_register(REG_FRAME_CENTER, with_junk($urandom_range(0, 1023), COL_W));
        set_register(REG_FRAME_WIDTH, CFG_DAT_W'(fw));
    endtask

    // two lane columns inside the search ranges, band rows, plus some noise beats
    task automatic send_frame(input int n_beats);
        int w;
        int lend;
        int lane_l;
        int lane_r;
        int row_hi;
        int kind;
        logic             pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        w = used_width();
        lend = (int'(m_left_end) < w) ? int'(m_left_end) : w;
        lane_l = (lend > 0) ? $urandom_range(0, lend - 1) : $urandom_range(0, 1023);
        lane_r = (int'(m_right_start) < w) ? $urandom_range(int'(m_right_start), w - 1)
                                           : $urandom_range(0, 1023);
        row_hi = int'(m_band_top) + int'(m_band_rows) - 1;
        if (row_hi > 127) row_hi = 127;
        for (int i = 0; i < n_beats; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                pix = 1'b1;
                col = COL_W'(((kind < 4) ? lane_l : lane_r) + $urandom_range(0, 1));
                row = (m_band_rows == 0) ? ROW_W'($urandom_range(0, 127))
                                         : ROW_W'($urandom_range(int'(m_band_top), row_hi));
            end else begin
                pix = 1'($urandom_range(0, 1));
                col = COL_W'($urandom_range(0, 1023));
                row = ROW_W'($urandom_range(0, 127));
            end
            send_beat(pix, col, row, i == n_beats - 1);
        end
    endtask

    task automatic test_random_frames();
        int n_frames;
        while (beats_sent < BEAT_TARGET) begin
            wait_idle();
            randomize_registers();
            n_frames = $urandom_range(2, 6);
            for (int f = 0; f < n_frames; f++) begin
                send_frame($urandom_range(1, 30));
                if ($urandom_range(0, 3) == 0) drain_results();
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_timer = $urandom_range(20, 300);
        end else begin
            stall_timer--;
        end
        case (stall_mode)
            STALL_NONE:    i_out_stall <= 1'b0;
            STALL_SCATTER: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (stall_run > 0) stall_run--;
                else if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 30);
                i_out_stall <= (stall_run > 0);
            end
        endcase
    end

    // result beat checker
    always @(posedge i_clk) begin : result_check
        t_lane_fix want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_fixes.size() == 0) begin
                report_mismatch("result beat with no frame end pending");
            end else begin
                want = pending_fixes.pop_front();
                check_field("left_pos", 32'(o_left_pos), 32'(want.left_pos));
                check_field("right_pos", 32'(o_right_pos), 32'(want.right_pos));
                check_field("lane_center", 32'(o_lane_center), 32'(want.lane_center));
                check_field("steer_offset", 32'(o_steer_offset), 32'(want.steer_offset));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lane_histogram_center_finder_core_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_saturation();
        test_random_frames();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_fixes.size() != 0)
            report_mismatch($sformatf("%0d frame results never delivered", pending_fixes.size()));
        if (mismatch_count == 0) begin
            $display("lane_histogram_center_finder_core_tb passed");
        end else begin
            $display("lane_histogram_center_finder_core_tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lhcf_pkg.sv
hw/rtl/lhcf_ctrl.sv
hw/rtl/lhcf_dp.sv
hw/rtl/lane_histogram_center_finder_core.sv
verif/lane_histogram_center_finder_core_tb.sv
